// File: hw/rtl/pomodoro_phase_timer_unit_defines.svh
// ----------------------------------------------------------------------------
// Pomodoro phase timer assertion macros
// Concurrent checks for the timer modules. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef POMODORO_PHASE_TIMER_UNIT_DEFINES_SVH
`define POMODORO_PHASE_TIMER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PPT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pomodoro phase timer check failed");
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pomodoro phase timer check failed");
`else
`define PPT_ASSERT_NOW(label, clk, rst, ante, cons)
`define PPT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/ppt_pkg.sv
// ----------------------------------------------------------------------------
// Pomodoro phase timer package
// Phase, operation and register codes, reset values and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ppt_pkg;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_FOCUS  = 3'd1;
   localparam logic [2:0] PH_PAUSED = 3'd2;
   localparam logic [2:0] PH_SHORT  = 3'd3;
   localparam logic [2:0] PH_LONG   = 3'd4;
   localparam logic [2:0] PH_ALARM  = 3'd5;

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_TAP    = 3'd1;
   localparam logic [2:0] OP_LONG   = 3'd2;
   localparam logic [2:0] OP_DOUBLE = 3'd3;
   localparam logic [2:0] OP_FLUSH  = 3'd4;

   localparam logic [1:0] REG_FOCUS_LEN = 2'd0;
   localparam logic [1:0] REG_SHORT_LEN = 2'd1;
   localparam logic [1:0] REG_LONG_LEN  = 2'd2;
   localparam logic [1:0] REG_PER_LONG  = 2'd3;

   localparam logic [21:0] FOCUS_LEN_RESET = 22'd1500000;
   localparam logic [21:0] SHORT_LEN_RESET = 22'd300000;
   localparam logic [21:0] LONG_LEN_RESET  = 22'd900000;
   localparam logic [3:0]  PER_LONG_RESET  = 4'd4;

   // Milliseconds to seconds: floor(x / 1000) == (x * MS_RECIP) >> MS_SHIFT for x < 2^23.
   localparam int          MS_SHIFT = 33;
   localparam logic [23:0] MS_RECIP = 24'd8589935;

   typedef struct packed {
      logic [21:0] focus_len;
      logic [21:0] short_len;
      logic [21:0] long_len;
      logic [3:0]  per_long;
   } cfg_type;

   typedef struct packed {
      logic        sess_inc;
      logic        fold;
      logic        clear;
      logic [22:0] accum;
      logic [3:0]  cur_slot;
      logic [3:0]  rd_slot;
   } stats_ctrl_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic [21:0] remaining;
      logic [3:0]  cycle;
      logic [3:0]  slot;
      logic        pending;
      logic        beep;
      logic        exit_req;
   } fsm_out_type;

endpackage

`default_nettype wire

// File: hw/rtl/ppt_csr.sv
// ----------------------------------------------------------------------------
// Pomodoro phase timer configuration registers
// Holds the phase lengths and the long break interval written over the CSR channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [21:0]       csr_wdata,
   output ppt_pkg::cfg_type       cfg
);

   ppt_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focus_len <= ppt_pkg::FOCUS_LEN_RESET;
         cfg_ff.short_len <= ppt_pkg::SHORT_LEN_RESET;
         cfg_ff.long_len  <= ppt_pkg::LONG_LEN_RESET;
         cfg_ff.per_long  <= ppt_pkg::PER_LONG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            ppt_pkg::REG_FOCUS_LEN: cfg_ff.focus_len <= csr_wdata;
            ppt_pkg::REG_SHORT_LEN: cfg_ff.short_len <= csr_wdata;
            ppt_pkg::REG_LONG_LEN:  cfg_ff.long_len  <= csr_wdata;
            ppt_pkg::REG_PER_LONG:  cfg_ff.per_long  <= csr_wdata[3:0];
         endcase
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/ppt_fsm.sv
// ----------------------------------------------------------------------------
// Pomodoro phase timer control
// Phase state machine, countdown, focus accumulator, cycle and slot selection.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pomodoro_phase_timer_unit_defines.svh"

module ppt_fsm #(
   parameter int NUM_SLOTS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [2:0]           op,
   input  wire logic [15:0]          elapsed,
   input  wire ppt_pkg::cfg_type     cfg,
   output ppt_pkg::stats_ctrl_type   stats_ctrl,
   output ppt_pkg::fsm_out_type      fsm_out
);

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  after_ff, after_in;
   logic [2:0]  before_ff, before_in;
   logic        counting_ff, counting_in;
   logic [22:0] accum_ff, accum_in;
   logic [21:0] time_left_ff, time_left_in;
   logic [3:0]  cycle_ff, cycle_in;
   logic        armed_ff, armed_in;
   logic [3:0]  slot_ff, slot_in;

   logic [22:0] acc_sum;
   logic [22:0] acc_cur;
   logic [3:0]  cycle_inc;
   logic [3:0]  slot_adv;
   logic        beep;
   logic        exit_req;
   logic        sess_inc;
   logic        fold;
   logic        clear;
   logic [22:0] fold_val;

   assign acc_sum   = accum_ff + 23'(elapsed);
   assign acc_cur   = (phase_ff == ppt_pkg::PH_FOCUS) ? acc_sum : accum_ff;
   assign cycle_inc = cycle_ff + 4'd1;
   assign slot_adv  = (slot_ff == 4'(NUM_SLOTS - 1)) ? 4'd0 : slot_ff + 4'd1;

   always_comb begin
      phase_in     = phase_ff;
      after_in     = after_ff;
      before_in    = before_ff;
      counting_in  = counting_ff;
      accum_in     = accum_ff;
      time_left_in = time_left_ff;
      cycle_in     = cycle_ff;
      armed_in     = armed_ff;
      slot_in      = slot_ff;
      beep         = 1'b0;
      exit_req     = 1'b0;
      sess_inc     = 1'b0;
      fold         = 1'b0;
      clear        = 1'b0;
      fold_val     = accum_ff;
      unique case (op)
         ppt_pkg::OP_TICK: begin
            if (counting_ff) begin
               accum_in = acc_cur;
               if (time_left_ff > 22'(elapsed)) begin
                  time_left_in = time_left_ff - 22'(elapsed);
               end else begin
                  time_left_in = '0;
                  if (phase_ff == ppt_pkg::PH_FOCUS) begin
                     sess_inc = 1'b1;
                     fold     = 1'b1;
                     fold_val = acc_cur;
                     accum_in = '0;
                     if (cycle_inc == cfg.per_long) begin
                        after_in = ppt_pkg::PH_LONG;
                        cycle_in = '0;
                     end else begin
                        after_in = ppt_pkg::PH_SHORT;
                        cycle_in = cycle_inc;
                     end
                  end else begin
                     after_in = ppt_pkg::PH_FOCUS;
                  end
                  phase_in    = ppt_pkg::PH_ALARM;
                  counting_in = 1'b0;
                  beep        = 1'b1;
               end
            end
         end
         ppt_pkg::OP_DOUBLE: begin
            if (phase_ff == ppt_pkg::PH_IDLE) begin
               exit_req = 1'b1;
            end else begin
               phase_in     = ppt_pkg::PH_IDLE;
               counting_in  = 1'b0;
               armed_in     = 1'b0;
               time_left_in = cfg.focus_len;
               accum_in     = '0;
            end
         end
         ppt_pkg::OP_TAP: begin
            if (phase_ff == ppt_pkg::PH_IDLE) begin
               if (!armed_ff) begin
                  slot_in = slot_adv;
               end
            end else if (phase_ff != ppt_pkg::PH_ALARM) begin
               armed_in = 1'b1;
            end
         end
         ppt_pkg::OP_LONG: begin
            priority if (phase_ff == ppt_pkg::PH_ALARM) begin
               phase_in    = after_ff;
               counting_in = 1'b1;
               if (after_ff == ppt_pkg::PH_SHORT) begin
                  time_left_in = cfg.short_len;
               end else if (after_ff == ppt_pkg::PH_LONG) begin
                  time_left_in = cfg.long_len;
               end else begin
                  time_left_in = cfg.focus_len;
               end
            end else if (armed_ff) begin
               clear    = 1'b1;
               armed_in = 1'b0;
            end else if (phase_ff == ppt_pkg::PH_IDLE) begin
               phase_in     = ppt_pkg::PH_FOCUS;
               time_left_in = cfg.focus_len;
               counting_in  = 1'b1;
            end else if (phase_ff == ppt_pkg::PH_PAUSED) begin
               phase_in    = before_ff;
               counting_in = 1'b1;
            end else begin
               before_in   = phase_ff;
               phase_in    = ppt_pkg::PH_PAUSED;
               counting_in = 1'b0;
            end
         end
         ppt_pkg::OP_FLUSH: begin
            if (phase_ff == ppt_pkg::PH_FOCUS && counting_ff) begin
               fold     = 1'b1;
               fold_val = accum_ff;
               accum_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ppt_pkg::PH_IDLE;
         after_ff     <= ppt_pkg::PH_IDLE;
         before_ff    <= ppt_pkg::PH_IDLE;
         counting_ff  <= 1'b0;
         accum_ff     <= '0;
         time_left_ff <= ppt_pkg::FOCUS_LEN_RESET;
         cycle_ff     <= '0;
         armed_ff     <= 1'b0;
         slot_ff      <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         after_ff     <= after_in;
         before_ff    <= before_in;
         counting_ff  <= counting_in;
         accum_ff     <= accum_in;
         time_left_ff <= time_left_in;
         cycle_ff     <= cycle_in;
         armed_ff     <= armed_in;
         slot_ff      <= slot_in;
      end
   end

   assign stats_ctrl.sess_inc = sess_inc;
   assign stats_ctrl.fold     = fold;
   assign stats_ctrl.clear    = clear;
   assign stats_ctrl.accum    = fold_val;
   assign stats_ctrl.cur_slot = slot_ff;
   assign stats_ctrl.rd_slot  = slot_in;

   assign fsm_out.phase     = phase_in;
   assign fsm_out.remaining = time_left_in;
   assign fsm_out.cycle     = cycle_in;
   assign fsm_out.slot      = slot_in;
   assign fsm_out.pending   = armed_in;
   assign fsm_out.beep      = beep;
   assign fsm_out.exit_req  = exit_req;

   `PPT_ASSERT_NOW(a_counting_phase, clock, reset, counting_ff,
      (phase_ff == ppt_pkg::PH_FOCUS || phase_ff == ppt_pkg::PH_SHORT ||
       phase_ff == ppt_pkg::PH_LONG))
   `PPT_ASSERT_NOW(a_alarm_expired, clock, reset, phase_ff == ppt_pkg::PH_ALARM,
      time_left_ff == '0)
   `PPT_ASSERT_NOW(a_pause_origin, clock, reset, phase_ff == ppt_pkg::PH_PAUSED,
      (before_ff == ppt_pkg::PH_FOCUS || before_ff == ppt_pkg::PH_SHORT ||
       before_ff == ppt_pkg::PH_LONG))

endmodule

`default_nettype wire

// File: hw/rtl/ppt_stats.sv
// ----------------------------------------------------------------------------
// Pomodoro phase timer slot statistics
// Per-slot focus seconds and session totals with fold, count and clear updates.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_stats #(
   parameter int NUM_SLOTS = 4
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire ppt_pkg::stats_ctrl_type  ctrl,
   output logic [31:0]                   seconds_out,
   output logic [31:0]                   sessions_out
);

   localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int PROD_W = 23 + 24;

   logic [31:0] seconds_mem [NUM_SLOTS];
   logic [31:0] sessions_mem [NUM_SLOTS];

   logic [IDX_W-1:0]  rd_idx;
   logic [IDX_W-1:0]  wr_idx;
   logic [PROD_W-1:0] prod;
   logic [13:0]       whole_sec;
   logic [31:0]       seconds_new;
   logic [31:0]       sessions_new;
   logic              wr_en;

   assign rd_idx    = ctrl.rd_slot[IDX_W-1:0];
   assign wr_idx    = ctrl.cur_slot[IDX_W-1:0];
   assign prod      = PROD_W'(ctrl.accum) * PROD_W'(ppt_pkg::MS_RECIP);
   assign whole_sec = prod[PROD_W-1:ppt_pkg::MS_SHIFT];
   assign wr_en     = step && (ctrl.fold || ctrl.sess_inc || ctrl.clear);

   always_comb begin
      seconds_new  = seconds_mem[rd_idx];
      sessions_new = sessions_mem[rd_idx];
      if (ctrl.clear) begin
         seconds_new  = '0;
         sessions_new = '0;
      end else begin
         if (ctrl.fold) begin
            seconds_new = seconds_new + 32'(whole_sec);
         end
         if (ctrl.sess_inc) begin
            sessions_new = sessions_new + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            seconds_mem[i]  <= '0;
            sessions_mem[i] <= '0;
         end
      end else if (wr_en) begin
         seconds_mem[wr_idx]  <= seconds_new;
         sessions_mem[wr_idx] <= sessions_new;
      end
   end

   assign seconds_out  = seconds_new;
   assign sessions_out = sessions_new;

endmodule

`default_nettype wire

// File: hw/rtl/pomodoro_phase_timer_unit.sv
// ----------------------------------------------------------------------------
// Pomodoro phase timer unit
// Event-driven focus/break timer with per-slot focus statistics.
// ----------------------------------------------------------------------------
// Each req transaction carries one event: the operation code in req_tuser and
// the elapsed milliseconds of a tick in req_tdata. Every event yields exactly
// one rsp transaction with the phase, the remaining time, the cycle count, the
// selected slot with its totals and the pending, beep and exit flags.
// An event is captured in an input register, evaluated combinationally and its
// result is stored in the output register, which drives rsp_tvalid and rsp_tdata.
// One event per cycle is sustained while the receiver keeps rsp_tready high; the
// loop that sets this is the update of the phase and slot registers.
// When the receiver holds rsp_tready low, the result waits in the output
// register and one more event may wait in the input register; req_tready then
// falls until the result is taken.
// The csr channel writes the phase lengths and long break interval and is always
// ready; length writes take effect when a phase is next loaded, and the interval at the next focus end.
// A synchronous reset returns the timer to idle with all slot totals cleared
// and the configuration at its default lengths; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pomodoro_phase_timer_unit_defines.svh"

module pomodoro_phase_timer_unit #(
   parameter int NUM_SLOTS = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [15:0]   req_tdata,   // [15:0] elapsed_ms
   input  wire logic [2:0]    req_tuser,   // [2:0] operation
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // [2:0] phase, [24:3] remaining_ms, [28:25] cycle_count, [32:29] slot_index,
   // [64:33] slot_seconds, [96:65] slot_sessions, [97] reset_pending,
   // [98] beep_request, [99] exit_request, [103:100] zero
   output logic [103:0]       rsp_tdata,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [21:0]   csr_wdata
);

   ppt_pkg::cfg_type        cfg;
   ppt_pkg::stats_ctrl_type stats_ctrl;
   ppt_pkg::fsm_out_type    fsm_out;

   logic         in_valid_ff;
   logic [2:0]   in_op_ff;
   logic [15:0]  in_elapsed_ff;
   logic         rsp_valid_ff;
   logic [103:0] rsp_data_ff;
   logic         step;
   logic [31:0]  seconds;
   logic [31:0]  sessions;

   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   ppt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ppt_fsm #(.NUM_SLOTS(NUM_SLOTS)) u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .op         (in_op_ff),
      .elapsed    (in_elapsed_ff),
      .cfg        (cfg),
      .stats_ctrl (stats_ctrl),
      .fsm_out    (fsm_out)
   );

   ppt_stats #(.NUM_SLOTS(NUM_SLOTS)) u_stats (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .ctrl         (stats_ctrl),
      .seconds_out  (seconds),
      .sessions_out (sessions)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff      <= req_tuser;
         in_elapsed_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= {4'b0000, fsm_out.exit_req, fsm_out.beep, fsm_out.pending,
                         sessions, seconds, fsm_out.slot, fsm_out.cycle,
                         fsm_out.remaining, fsm_out.phase};
      end
   end

   `PPT_ASSERT_NOW(a_beep_in_alarm, clock, reset, rsp_tvalid && rsp_tdata[98],
      rsp_tdata[2:0] == ppt_pkg::PH_ALARM)
   `PPT_ASSERT_NOW(a_exit_in_idle, clock, reset, rsp_tvalid && rsp_tdata[99],
      rsp_tdata[2:0] == ppt_pkg::PH_IDLE)
   `PPT_ASSERT_NOW(a_slot_range, clock, reset, rsp_tvalid,
      {1'b0, rsp_tdata[32:29]} < 5'(NUM_SLOTS))
   `PPT_ASSERT_NEXT(a_held_item, clock, reset, in_valid_ff && !step, in_valid_ff)

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Pomodoro phase timer unit testbench
// Streams tick, gesture and flush events into the timer while a built-in
// timer model predicts the status of every event. Each status transaction is
// checked field by field against the model. The run covers several phase
// length settings, including zero and full-scale lengths, with random stalls
// on both streams.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          SLOTS           = 4;
   localparam int          IDLE_PCT        = 36;
   localparam int          RUN_LIMIT       = 300000;
   localparam int          MS_PER_S        = 1000;
   localparam logic [2:0]  OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0]  OP_UNUSED_LAST  = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] ms;
   } timer_event_type;

   typedef struct packed {
      logic        exit_req;
      logic        beep;
      logic        pending;
      logic [31:0] sessions;
      logic [31:0] seconds;
      logic [3:0]  slot;
      logic [3:0]  cycle;
      logic [21:0] remaining;
      logic [2:0]  phase;
   } timer_status_type;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [15:0]   req_tdata  = '0;
   logic [2:0]    req_tuser  = ppt_pkg::OP_TICK;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index  = ppt_pkg::REG_FOCUS_LEN;
   logic [21:0]   csr_wdata  = '0;

   timer_event_type  event_q[$];
   timer_status_type status_q[$];
   timer_event_type  next_event;
   int               events_sent = 0;
   int               errors      = 0;
   int               tick_span   = 65535;
   int               hold_left   = 0;
   logic             hold_done   = 1'b0;
   int unsigned      run_cycles  = 0;

   logic [2:0]  t_phase, t_resume_phase, t_paused_from;
   logic        t_running, t_armed;
   logic [22:0] t_focus_ms;
   logic [21:0] t_left;
   logic [3:0]  t_cycle, t_slot;
   logic [31:0] slot_secs [SLOTS];
   logic [31:0] slot_sess [SLOTS];
   logic [21:0] len_focus, len_short, len_long;
   logic [3:0]  focus_per_long;

   pomodoro_phase_timer_unit #(.NUM_SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void fold_focus();
      if (t_focus_ms != '0) begin
         slot_secs[t_slot] = slot_secs[t_slot] + 32'(t_focus_ms / MS_PER_S);
         t_focus_ms = '0;
      end
   endfunction

   function automatic timer_status_type advance_timer(logic [2:0] op, logic [15:0] ms);
      timer_status_type st;
      st = '0;
      case (op)
         ppt_pkg::OP_TICK: begin
            if (t_running) begin
               if (t_phase == ppt_pkg::PH_FOCUS) t_focus_ms = t_focus_ms + 23'(ms);
               if (t_left > 22'(ms)) begin
                  t_left = t_left - 22'(ms);
               end else begin
                  t_left = '0;
                  if (t_phase == ppt_pkg::PH_FOCUS) begin
                     slot_sess[t_slot] = slot_sess[t_slot] + 32'd1;
                     fold_focus();
                     t_cycle = t_cycle + 4'd1;
                     if (t_cycle == focus_per_long) begin
                        t_resume_phase = ppt_pkg::PH_LONG;
                        t_cycle = '0;
                     end else begin
                        t_resume_phase = ppt_pkg::PH_SHORT;
                     end
                  end else begin
                     t_resume_phase = ppt_pkg::PH_FOCUS;
                  end
                  t_phase = ppt_pkg::PH_ALARM;
                  t_running = 1'b0;
                  st.beep = 1'b1;
               end
            end
         end
         ppt_pkg::OP_TAP: begin
            if (t_phase != ppt_pkg::PH_ALARM) begin
               if (t_phase == ppt_pkg::PH_IDLE && !t_armed)
                  t_slot = 4'((t_slot + 1) % SLOTS);
               if (t_phase != ppt_pkg::PH_IDLE) t_armed = 1'b1;
            end
         end
         ppt_pkg::OP_LONG: begin
            if (t_phase == ppt_pkg::PH_ALARM) begin
               t_phase = t_resume_phase;
               if (t_phase == ppt_pkg::PH_SHORT) t_left = len_short;
               else if (t_phase == ppt_pkg::PH_LONG) t_left = len_long;
               else t_left = len_focus;
               t_running = 1'b1;
            end else if (t_armed) begin
               slot_secs[t_slot] = '0;
               slot_sess[t_slot] = '0;
               t_armed = 1'b0;
            end else if (t_phase == ppt_pkg::PH_IDLE) begin
               t_phase = ppt_pkg::PH_FOCUS;
               t_left = len_focus;
               t_running = 1'b1;
            end else if (t_phase == ppt_pkg::PH_PAUSED) begin
               t_phase = t_paused_from;
               t_running = 1'b1;
            end else begin
               t_paused_from = t_phase;
               t_phase = ppt_pkg::PH_PAUSED;
               t_running = 1'b0;
            end
         end
         ppt_pkg::OP_DOUBLE: begin
            if (t_phase == ppt_pkg::PH_IDLE) begin
               st.exit_req = 1'b1;
            end else begin
               t_phase = ppt_pkg::PH_IDLE;
               t_running = 1'b0;
               t_armed = 1'b0;
               t_left = len_focus;
               t_focus_ms = '0;
            end
         end
         ppt_pkg::OP_FLUSH: begin
            if (t_phase == ppt_pkg::PH_FOCUS && t_running) fold_focus();
         end
         default: ;
      endcase
      st.phase     = t_phase;
      st.remaining = t_left;
      st.cycle     = t_cycle;
      st.slot      = t_slot;
      st.seconds   = slot_secs[t_slot];
      st.sessions  = slot_sess[t_slot];
      st.pending   = t_armed;
      return st;
   endfunction

   function automatic logic quiet_window();
      return events_sent >= 600 && events_sent < 800;
   endfunction

   function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   function automatic void check_status(timer_status_type want, logic [103:0] bits);
      timer_status_type got;
      got = timer_status_type'(bits[99:0]);
      report_field("phase", 32'(want.phase), 32'(got.phase));
      report_field("remaining_ms", 32'(want.remaining), 32'(got.remaining));
      report_field("cycle_count", 32'(want.cycle), 32'(got.cycle));
      report_field("slot_index", 32'(want.slot), 32'(got.slot));
      report_field("slot_seconds", want.seconds, got.seconds);
      report_field("slot_sessions", want.sessions, got.sessions);
      report_field("reset_pending", 32'(want.pending), 32'(got.pending));
      report_field("beep_request", 32'(want.beep), 32'(got.beep));
      report_field("exit_request", 32'(want.exit_req), 32'(got.exit_req));
      report_field("padding", 32'd0, 32'(bits[103:100]));
   endfunction

   function automatic timer_event_type random_event();
      timer_event_type ev;
      int pick;
      pick = $urandom_range(0, 99);
      ev.ms = 16'($urandom);
      if (pick < 48) begin
         ev.op = ppt_pkg::OP_TICK;
         case ($urandom_range(0, 9))
            0: ev.ms = '0;
            1: ev.ms = '1;
            2, 3: ;
            default: ev.ms = 16'($urandom_range(0, tick_span));
         endcase
      end else if (pick < 66) begin
         ev.op = ppt_pkg::OP_LONG;
      end else if (pick < 76) begin
         ev.op = ppt_pkg::OP_TAP;
      end else if (pick < 86) begin
         ev.op = ppt_pkg::OP_FLUSH;
      end else if (pick < 94) begin
         ev.op = ppt_pkg::OP_DOUBLE;
      end else begin
         ev.op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end
      return ev;
   endfunction

   task automatic push_event(logic [2:0] op, logic [15:0] ms);
      timer_event_type ev;
      ev.op = op;
      ev.ms = ms;
      event_q.push_back(ev);
   endtask

   task automatic queue_random(int count);
      repeat (count) event_q.push_back(random_event());
   endtask

   task automatic settle();
      do @(negedge clock);
      while (event_q.size() != 0 || req_tvalid || status_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [21:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         ppt_pkg::REG_FOCUS_LEN: len_focus = value;
         ppt_pkg::REG_SHORT_LEN: len_short = value;
         ppt_pkg::REG_LONG_LEN:  len_long = value;
         ppt_pkg::REG_PER_LONG:  focus_per_long = value[3:0];
         default: ;
      endcase
   endtask

   task automatic program_timer(logic [21:0] focus, logic [21:0] short_len,
                                logic [21:0] long_len, logic [3:0] per_long);
      write_reg(ppt_pkg::REG_FOCUS_LEN, focus);
      write_reg(ppt_pkg::REG_SHORT_LEN, short_len);
      write_reg(ppt_pkg::REG_LONG_LEN, long_len);
      write_reg(ppt_pkg::REG_PER_LONG, 22'(per_long));
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            status_q.push_back(advance_timer(req_tuser, req_tdata));
            events_sent <= events_sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (event_q.size() != 0 &&
                (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
               next_event = event_q.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_event.op;
               req_tdata  <= next_event.ms;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (status_q.size() == 0) begin
               errors++;
               $display("%0t: status transaction expected none, actual %0h", $time, rsp_tdata);
            end else begin
               check_status(status_q.pop_front(), rsp_tdata);
            end
         end
         if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_done && events_sent >= 450 && event_q.size() > 16) begin
            hold_left  <= 80;
            hold_done  <= 1'b1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet_window() || $urandom_range(0, 99) >= IDLE_PCT;
         end
      end
   end

   always @(posedge clock) begin
      run_cycles <= run_cycles + 1;
      if (run_cycles >= RUN_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      len_focus      = ppt_pkg::FOCUS_LEN_RESET;
      len_short      = ppt_pkg::SHORT_LEN_RESET;
      len_long       = ppt_pkg::LONG_LEN_RESET;
      focus_per_long = ppt_pkg::PER_LONG_RESET;
      t_phase        = ppt_pkg::PH_IDLE;
      t_resume_phase = ppt_pkg::PH_IDLE;
      t_paused_from  = ppt_pkg::PH_IDLE;
      t_running      = 1'b0;
      t_armed        = 1'b0;
      t_focus_ms     = '0;
      t_left         = ppt_pkg::FOCUS_LEN_RESET;
      t_cycle        = '0;
      t_slot         = '0;
      foreach (slot_secs[i]) begin
         slot_secs[i] = '0;
         slot_sess[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_event(ppt_pkg::OP_DOUBLE, 16'h0000);
      push_event(ppt_pkg::OP_TAP, 16'hFFFF);
      push_event(ppt_pkg::OP_TICK, 16'hFFFF);
      push_event(ppt_pkg::OP_FLUSH, 16'h0000);
      push_event(OP_UNUSED_FIRST, 16'h5A5A);
      push_event(OP_UNUSED_FIRST + 3'd1, 16'hA5A5);
      push_event(OP_UNUSED_LAST, 16'hFFFF);
      push_event(ppt_pkg::OP_LONG, 16'h0000);
      push_event(ppt_pkg::OP_TICK, 16'h0000);
      push_event(ppt_pkg::OP_TICK, 16'hFFFF);
      push_event(ppt_pkg::OP_FLUSH, 16'h0000);
      push_event(ppt_pkg::OP_LONG, 16'h0000);
      push_event(ppt_pkg::OP_TICK, 16'h1234);
      push_event(ppt_pkg::OP_LONG, 16'h0000);
      push_event(ppt_pkg::OP_TAP, 16'h0000);
      push_event(ppt_pkg::OP_LONG, 16'h0000);
      push_event(ppt_pkg::OP_DOUBLE, 16'h0000);
      settle();

      program_timer('0, '0, '0, '0);
      push_event(ppt_pkg::OP_LONG, 16'h0000);
      push_event(ppt_pkg::OP_TICK, 16'h0000);
      push_event(ppt_pkg::OP_TAP, 16'h0000);
      push_event(ppt_pkg::OP_FLUSH, 16'h0000);
      push_event(ppt_pkg::OP_TICK, 16'h0010);
      push_event(ppt_pkg::OP_LONG, 16'h0000);
      push_event(ppt_pkg::OP_TICK, 16'h0064);
      push_event(ppt_pkg::OP_LONG, 16'h0000);
      push_event(ppt_pkg::OP_DOUBLE, 16'h0000);
      tick_span = 100;
      queue_random(120);
      settle();

      program_timer('1, '1, '1, 4'd15);
      tick_span = 65535;
      queue_random(150);
      settle();

      repeat (5) begin
         program_timer(22'($urandom_range(1, 30000)), 22'($urandom_range(1, 10000)),
                       22'($urandom_range(1, 20000)), 4'($urandom_range(1, 15)));
         tick_span = $urandom_range(200, 8000);
         queue_random(150);
         settle();
      end

      program_timer(22'd1, 22'd1, 22'd1, 4'd1);
      tick_span = 3;
      queue_random(100);
      settle();

      program_timer(ppt_pkg::FOCUS_LEN_RESET, ppt_pkg::SHORT_LEN_RESET,
                    ppt_pkg::LONG_LEN_RESET, ppt_pkg::PER_LONG_RESET);
      tick_span = 65535;
      queue_random(150);
      settle();

      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
